/* rtl/afp_pkg.sv */
package afp_pkg;

  localparam int unsigned POSITION_BITS = 32;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] HDR_LEN = POSITION_BITS'(64);
  localparam logic [15:0] BLOCK_HEAD = 16'd16;
  localparam logic [15:0] ADPCM_SKIP = 16'd24;
  localparam logic [15:0] ADPCM_BLOCK_LEN = 16'd344;  // 328 payload plus 16 head
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [7:0] OPUS_CODE_RST = 8'd2;
  localparam logic [7:0] ADPCM_CODE_RST = 8'd1;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned TDATA_W = 192;

  typedef enum logic [2:0] {
    ST_PAYLOAD = 3'd0,
    ST_OK      = 3'd1,
    ST_HDR_ERR = 3'd2,
    ST_CRC_ERR = 3'd3,
    ST_BLK_ERR = 3'd4,
    ST_CNT_ERR = 3'd5
  } status_e;

  typedef enum logic {
    REG_OPUS  = 1'b0,
    REG_ADPCM = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  version;
    logic [15:0] session;
    logic [47:0] call;
    logic [31:0] start_time;
    logic [31:0] frame_time;
    logic [31:0] frame_len;
    logic [15:0] blocks;
    logic [31:0] crc_want;
    logic [7:0]  depth;
  } hdr_t;

  typedef struct packed {
    status_e     status;
    logic        last_blk;
    logic [TDATA_W-1:0] data;
  } result_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic [7:0] marker_byte(logic [15:0] o);
    logic [7:0] m;
    case (o)
      16'd11:  m = 8'h3d;
      16'd12:  m = 8'h14;
      16'd13:  m = 8'h00;
      16'd14:  m = 8'he0;
      default: m = 8'h3d;
    endcase
    return m;
  endfunction

endpackage

/* rtl/afp_out_fifo.sv */
module afp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        wr_n_i,
  input  afp_pkg::result_t  item_a_i,
  input  afp_pkg::result_t  item_b_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              pop_i,
  output afp_pkg::result_t  item_o
);
  import afp_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  result_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q, cnt_d;
  logic            pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= (PW+1)'(FIFO_DEPTH - 2);
  assign item_o  = mem_q[rp_q];
  assign cnt_d   = cnt_q + (PW+1)'(wr_n_i) - (PW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) mem_q[wp_q] <= item_a_i;
    if (wr_n_i == 2'd2) mem_q[wp_q + PW'(1)] <= item_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PW'(wr_n_i);
      rp_q  <= rp_q + PW'(pop);
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(FIFO_DEPTH)) else $error("fifo count overflow");
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_n_i != 2'd0) |-> room_o) else $error("write without room");
  a_pop_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && wr_n_i == 2'd0) |=> cnt_q == $past(cnt_q) - (PW+1)'(1))
    else $error("pop did not drain");
`endif

endmodule

/* rtl/audio_frame_parser.sv */
// channel   dir  handshake              contents
// s_axis    in   tvalid/tready          tdata frame byte, tlast end of frame
// m_axis    out  tvalid/tready          tuser status, tdata fields, tlast block end
// cfg       in   cfg_we_i, no ready     cfg_idx_i register, cfg_data_i value
//
// one byte per cycle: header capture, crc update and block walk are all
// done in the accept cycle and the results land in a 4-entry output queue
// each byte gives zero, one or two words; input stalls only when the queue
// has fewer than two free slots
// reset clears frame state and queue and restores the codec codes
module audio_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] codec_is_adpcm, [24:9] start_sample,
  // [32:25] start_index, [48:33] session_id, [96:49] station_call,
  // [128:97] start_time, [160:129] frame_time, [176:161] declared_blocks,
  // [184:177] jitter_depth, rest zero
  output logic [afp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast,   // last_of_block
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import afp_pkg::*;

  logic [7:0] opus_code_q, adpcm_code_q;

  // frame state
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [31:0] crc_q, crc_d;
  hdr_t        hdr_q, hdr_d;
  logic [15:0] off_q, off_d, blen_q, blen_d, ilen_q, ilen_d;
  logic [7:0]  codec_q, codec_d;
  logic [23:0] astart_q, astart_d;
  logic [15:0] seen_q, seen_d;
  logic        err_q, err_d;

  logic        accept;
  logic [1:0]  wr_n;
  result_t     pay_item, stat_item, item_a, item_b, out_item;
  logic        emit, is_adpcm, is_opus;
  status_e     verdict;
  logic [7:0]  b;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opus_code_q  <= OPUS_CODE_RST;
      adpcm_code_q <= ADPCM_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OPUS:  opus_code_q  <= cfg_data_i;
        REG_ADPCM: adpcm_code_q <= cfg_data_i;
        default:   opus_code_q  <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    hdr_d    = hdr_q;
    off_d    = off_q;
    blen_d   = blen_q;
    ilen_d   = ilen_q;
    codec_d  = codec_q;
    astart_d = astart_q;
    seen_d   = seen_q;
    err_d    = err_q;
    emit     = 1'b0;
    is_adpcm = codec_q == adpcm_code_q;
    is_opus  = !is_adpcm && codec_q == opus_code_q;

    if (pos_q < HDR_LEN) begin
      // little-endian header capture
      case (pos_q[5:0])
        6'd0:  hdr_d.version = b;
        6'd6:  hdr_d.session[7:0] = b;
        6'd7:  hdr_d.session[15:8] = b;
        6'd10: hdr_d.call[7:0] = b;
        6'd11: hdr_d.call[15:8] = b;
        6'd12: hdr_d.call[23:16] = b;
        6'd13: hdr_d.call[31:24] = b;
        6'd14: hdr_d.call[39:32] = b;
        6'd15: hdr_d.call[47:40] = b;
        6'd22: hdr_d.start_time[7:0] = b;
        6'd23: hdr_d.start_time[15:8] = b;
        6'd24: hdr_d.start_time[23:16] = b;
        6'd25: hdr_d.start_time[31:24] = b;
        6'd26: hdr_d.frame_time[7:0] = b;
        6'd27: hdr_d.frame_time[15:8] = b;
        6'd28: hdr_d.frame_time[23:16] = b;
        6'd29: hdr_d.frame_time[31:24] = b;
        6'd30: hdr_d.frame_len[7:0] = b;
        6'd31: hdr_d.frame_len[15:8] = b;
        6'd32: hdr_d.frame_len[23:16] = b;
        6'd33: hdr_d.frame_len[31:24] = b;
        6'd34: hdr_d.blocks[7:0] = b;
        6'd35: hdr_d.blocks[15:8] = b;
        6'd36: hdr_d.crc_want[7:0] = b;
        6'd37: hdr_d.crc_want[15:8] = b;
        6'd38: hdr_d.crc_want[23:16] = b;
        6'd39: hdr_d.crc_want[31:24] = b;
        6'd40: hdr_d.depth = b;
        default: ;
      endcase
    end else begin
      crc_d = crc32_byte(crc_q, b);
      // block walk stops after the first block error
      if (!err_q) begin
        if (off_q == 16'd0) begin
          blen_d   = '0;
          ilen_d   = '0;
          codec_d  = '0;
          astart_d = '0;
        end
        if (off_q == 16'd2) blen_d = {8'd0, b};
        else if (off_q == 16'd3) begin
          blen_d = {b, blen_q[7:0]};
          if (blen_d < BLOCK_HEAD) err_d = 1'b1;
        end else if (off_q == 16'd8) codec_d = b;
        else if (off_q == 16'd9) ilen_d = {8'd0, b};
        else if (off_q == 16'd10) begin
          ilen_d = {b, ilen_q[7:0]};
          if (ilen_d != blen_q - 16'd8) err_d = 1'b1;
        end else if (off_q >= 16'd11 && off_q <= 16'd15) begin
          if (b != marker_byte(off_q)) err_d = 1'b1;
          if (off_q == 16'd15 && is_adpcm && blen_q != ADPCM_BLOCK_LEN) err_d = 1'b1;
        end else if (is_adpcm && off_q == 16'd18) astart_d[7:0] = b;
        else if (is_adpcm && off_q == 16'd19) astart_d[15:8] = b;
        else if (is_adpcm && off_q == 16'd20) astart_d[23:16] = b;

        if (!err_d) begin
          emit = (is_opus && off_q >= BLOCK_HEAD) || (is_adpcm && off_q >= ADPCM_SKIP);
          if (off_q >= 16'd3 && {1'b0, off_q} + 17'd1 == {1'b0, blen_d}) begin
            seen_d = seen_q + 16'd1;
            off_d  = '0;
          end else begin
            off_d = off_q + 16'd1;
          end
        end
      end
    end
    if (pos_q != POS_MAX) pos_d = pos_q + POSITION_BITS'(1);

    // verdict, in priority order
    if (pos_q == POS_MAX || pos_q < HDR_LEN - POSITION_BITS'(1) || hdr_d.version != 8'd1 ||
        hdr_d.frame_len != 32'(pos_q + POSITION_BITS'(1)))
      verdict = ST_HDR_ERR;
    else if (~crc_d != hdr_d.crc_want)
      verdict = ST_CRC_ERR;
    else if (err_d || off_d != 16'd0)
      verdict = ST_BLK_ERR;
    else if (seen_d != hdr_d.blocks)
      verdict = ST_CNT_ERR;
    else
      verdict = ST_OK;

    pay_item          = '0;
    pay_item.status   = ST_PAYLOAD;
    pay_item.last_blk = {1'b0, off_q} + 17'd1 == {1'b0, blen_d};
    pay_item.data[7:0] = b;
    if (is_adpcm) begin
      pay_item.data[8]     = 1'b1;
      pay_item.data[24:9]  = astart_d[15:0];
      pay_item.data[32:25] = astart_d[23:16];
    end

    stat_item              = '0;
    stat_item.status       = verdict;
    stat_item.data[48:33]  = hdr_d.session;
    stat_item.data[96:49]  = hdr_d.call;
    stat_item.data[128:97] = hdr_d.start_time;
    stat_item.data[160:129] = hdr_d.frame_time;
    stat_item.data[176:161] = hdr_d.blocks;
    stat_item.data[184:177] = hdr_d.depth;

    item_a = emit ? pay_item : stat_item;
    item_b = stat_item;
    wr_n   = accept ? (2'(emit) + 2'(s_axis_tlast)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= '1;
      hdr_q    <= '0;
      off_q    <= '0;
      blen_q   <= '0;
      ilen_q   <= '0;
      codec_q  <= '0;
      astart_q <= '0;
      seen_q   <= '0;
      err_q    <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        // verdict given, back to a clean frame
        pos_q    <= '0;
        crc_q    <= '1;
        hdr_q    <= '0;
        off_q    <= '0;
        blen_q   <= '0;
        ilen_q   <= '0;
        codec_q  <= '0;
        astart_q <= '0;
        seen_q   <= '0;
        err_q    <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        crc_q    <= crc_d;
        hdr_q    <= hdr_d;
        off_q    <= off_d;
        blen_q   <= blen_d;
        ilen_q   <= ilen_d;
        codec_q  <= codec_d;
        astart_q <= astart_d;
        seen_q   <= seen_d;
        err_q    <= err_d;
      end
    end
  end

  afp_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_n_i   (wr_n),
    .item_a_i (item_a),
    .item_b_i (item_b),
    .room_o   (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .pop_i    (m_axis_tready),
    .item_o   (out_item)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tuser = out_item.status;
  assign m_axis_tlast = out_item.last_blk;

endmodule
